### hw/rtl/omg_pkg.sv
// Shared types and constants for the object map gated association block.
// No dependencies.
package omg_pkg;

    localparam int NUM_GATES = 5;
    localparam int GATE_BITS = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CLASS_BITS = 5;
    localparam int EXT_BITS = 16;
    localparam int CONF_BITS = 16;
    localparam int GSQ_BITS = 2 * GATE_BITS;
    localparam int ACTION_BITS = 2;
    localparam int ID_BITS = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_GATE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTLE_GATE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHAIR_GATE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERSON_GATE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MONITOR_GATE = 3'd4;

    localparam logic [GATE_BITS-1:0] DEFAULT_GATE_RST = 16'd614;
    localparam logic [GATE_BITS-1:0] BOTTLE_GATE_RST  = 16'd61;
    localparam logic [GATE_BITS-1:0] CHAIR_GATE_RST   = 16'd512;
    localparam logic [GATE_BITS-1:0] PERSON_GATE_RST  = 16'd358;
    localparam logic [GATE_BITS-1:0] MONITOR_GATE_RST = 16'd256;

    localparam logic [CLASS_BITS-1:0] CLASS_BOTTLE  = 5'd5;
    localparam logic [CLASS_BITS-1:0] CLASS_CHAIR   = 5'd9;
    localparam logic [CLASS_BITS-1:0] CLASS_PERSON  = 5'd15;
    localparam logic [CLASS_BITS-1:0] CLASS_MONITOR = 5'd20;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT = 2'd0,
        ACT_MERGE  = 2'd1,
        ACT_DROP   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_back_state;

endpackage

### hw/rtl/omg_if.sv
// Channel interfaces: detections in, register writes, association results out.
// Depends on omg_pkg.
interface omg_in_if #(parameter int COORD_BITS = 16);
    logic                                valid;
    logic                                ready;
    logic [omg_pkg::CLASS_BITS-1:0]      obj_class;
    logic signed [COORD_BITS-1:0]        centre_x;
    logic signed [COORD_BITS-1:0]        centre_y;
    logic signed [COORD_BITS-1:0]        centre_z;
    logic [omg_pkg::EXT_BITS-1:0]        extent_x;
    logic [omg_pkg::EXT_BITS-1:0]        extent_y;
    logic [omg_pkg::EXT_BITS-1:0]        extent_z;
    logic [omg_pkg::CONF_BITS-1:0]       confidence;
    modport source (output valid, obj_class, centre_x, centre_y, centre_z,
                    extent_x, extent_y, extent_z, confidence, input ready);
    modport sink (input valid, obj_class, centre_x, centre_y, centre_z,
                  extent_x, extent_y, extent_z, confidence, output ready);
endinterface

interface omg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [omg_pkg::CFG_IDX_BITS-1:0]    index;
    logic [omg_pkg::GATE_BITS-1:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface omg_out_if;
    logic                                valid;
    logic                                ready;
    logic [omg_pkg::ACTION_BITS-1:0]     action;
    logic [omg_pkg::ID_BITS-1:0]         track_id;
    logic [omg_pkg::ID_BITS-1:0]         entries_used;
    modport source (output valid, action, track_id, entries_used, input ready);
    modport sink (input valid, action, track_id, entries_used, output ready);
endinterface

### hw/rtl/object_map_gated_association_core.sv
// Top level of the object map gated association block.
// Depends on omg_pkg, omg_if, omg_front, omg_queue and omg_back.
//
// Each detection is matched against the stored objects of its class; the
// nearest centroid within the class gate is merged, otherwise the detection
// is appended, or dropped when the table is full. A detection passes through
// the front register and the queue, then a scan start, a scan that reads one
// stored object per cycle from the single memory read port, a drain of the
// distance pipeline and a decision. The back end takes no new detection until
// its decision is done, and holds in the decision cycle while the previous
// result has not been taken. The front end and a two-entry queue take
// further detections while a scan runs. Register writes are taken every
// cycle; write them only while no detection is in flight. No clearing pass
// is needed at reset.
module object_map_gated_association_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    omg_in_if.sink     i_in,
    omg_cfg_if.sink    i_cfg,
    omg_out_if.source  o_out
);
    localparam int CMD_BITS = omg_pkg::CLASS_BITS + 3 * COORD_BITS
                            + 3 * omg_pkg::EXT_BITS + omg_pkg::CONF_BITS
                            + omg_pkg::GSQ_BITS;

    logic                f_valid;
    logic                f_ready;
    logic [CMD_BITS-1:0] f_cmd;
    logic                q_valid;
    logic                q_ready;
    logic [CMD_BITS-1:0] q_cmd;

    omg_front #(.COORD_BITS(COORD_BITS), .CMD_BITS(CMD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_obj_class  (i_in.obj_class),
        .i_centre_x   (i_in.centre_x),
        .i_centre_y   (i_in.centre_y),
        .i_centre_z   (i_in.centre_z),
        .i_extent_x   (i_in.extent_x),
        .i_extent_y   (i_in.extent_y),
        .i_extent_z   (i_in.extent_z),
        .i_confidence (i_in.confidence),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (f_ready),
        .o_cmd        (f_cmd)
    );

    omg_queue #(.WIDTH(CMD_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_cmd)
    );

    omg_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS),
        .CMD_BITS    (CMD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_ready    (q_ready),
        .i_cmd          (q_cmd),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_action       (o_out.action),
        .o_track_id     (o_out.track_id),
        .o_entries_used (o_out.entries_used)
    );
endmodule

### hw/rtl/omg_front.sv
// Front end: gate registers, detection intake, gate lookup and squaring.
// Depends on omg_pkg.
module omg_front #(
    parameter int COORD_BITS = 16,
    parameter int CMD_BITS = 5 + 3 * 16 + 64 + 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [omg_pkg::CLASS_BITS-1:0]  i_obj_class,
    input  logic signed [COORD_BITS-1:0]    i_centre_x,
    input  logic signed [COORD_BITS-1:0]    i_centre_y,
    input  logic signed [COORD_BITS-1:0]    i_centre_z,
    input  logic [omg_pkg::EXT_BITS-1:0]    i_extent_x,
    input  logic [omg_pkg::EXT_BITS-1:0]    i_extent_y,
    input  logic [omg_pkg::EXT_BITS-1:0]    i_extent_z,
    input  logic [omg_pkg::CONF_BITS-1:0]   i_confidence,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [omg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [omg_pkg::GATE_BITS-1:0]   i_cfg_data,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output logic [CMD_BITS-1:0]             o_cmd
);
    typedef struct packed {
        logic [omg_pkg::CLASS_BITS-1:0] cls;
        logic [COORD_BITS-1:0]          cx;
        logic [COORD_BITS-1:0]          cy;
        logic [COORD_BITS-1:0]          cz;
        logic [omg_pkg::EXT_BITS-1:0]   ex;
        logic [omg_pkg::EXT_BITS-1:0]   ey;
        logic [omg_pkg::EXT_BITS-1:0]   ez;
        logic [omg_pkg::CONF_BITS-1:0]  conf;
        logic [omg_pkg::GSQ_BITS-1:0]   gsq;
    } t_cmd;

    logic [omg_pkg::GATE_BITS-1:0] r_gate [omg_pkg::NUM_GATES];
    logic                          r_v;
    t_cmd                          r_cmd;
    t_cmd                          n_cmd;
    logic [omg_pkg::GATE_BITS-1:0] gate_sel;
    logic                          take;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_v || i_cmd_ready;
    assign take        = i_valid && o_ready;
    assign o_cmd_valid = r_v;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate[0] <= omg_pkg::DEFAULT_GATE_RST;
            r_gate[1] <= omg_pkg::BOTTLE_GATE_RST;
            r_gate[2] <= omg_pkg::CHAIR_GATE_RST;
            r_gate[3] <= omg_pkg::PERSON_GATE_RST;
            r_gate[4] <= omg_pkg::MONITOR_GATE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                omg_pkg::REG_DEFAULT_GATE: r_gate[0] <= i_cfg_data;
                omg_pkg::REG_BOTTLE_GATE:  r_gate[1] <= i_cfg_data;
                omg_pkg::REG_CHAIR_GATE:   r_gate[2] <= i_cfg_data;
                omg_pkg::REG_PERSON_GATE:  r_gate[3] <= i_cfg_data;
                omg_pkg::REG_MONITOR_GATE: r_gate[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_obj_class)
            omg_pkg::CLASS_BOTTLE:  gate_sel = r_gate[1];
            omg_pkg::CLASS_CHAIR:   gate_sel = r_gate[2];
            omg_pkg::CLASS_PERSON:  gate_sel = r_gate[3];
            omg_pkg::CLASS_MONITOR: gate_sel = r_gate[4];
            default:                gate_sel = r_gate[0];
        endcase
        n_cmd.cls  = i_obj_class;
        n_cmd.cx   = i_centre_x;
        n_cmd.cy   = i_centre_y;
        n_cmd.cz   = i_centre_z;
        n_cmd.ex   = i_extent_x;
        n_cmd.ey   = i_extent_y;
        n_cmd.ez   = i_extent_z;
        n_cmd.conf = i_confidence;
        n_cmd.gsq  = gate_sel * gate_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

### hw/rtl/omg_queue.sv
// Two-entry queue that decouples the front end from the table scan.
// No dependencies.
module omg_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_buf [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_data;
        end
    end
endmodule

### hw/rtl/omg_back.sv
// Back end: object table memory, nearest same-class scan, merge or append.
// Depends on omg_pkg.
module omg_back #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS = 16,
    parameter int CMD_BITS = 5 + 3 * 16 + 64 + 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  logic [CMD_BITS-1:0]               i_cmd,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [omg_pkg::ACTION_BITS-1:0]   o_action,
    output logic [omg_pkg::ID_BITS-1:0]       o_track_id,
    output logic [omg_pkg::ID_BITS-1:0]       o_entries_used
);
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int SQW  = 2 * COORD_BITS + 2;
    localparam int SW   = SQW + 2;
    localparam int CMPW = (SW > omg_pkg::GSQ_BITS) ? SW : omg_pkg::GSQ_BITS;
    localparam logic [CNTW-1:0] FULL = CNTW'(TABLE_DEPTH);

    typedef struct packed {
        logic [omg_pkg::CLASS_BITS-1:0] cls;
        logic [COORD_BITS-1:0]          cx;
        logic [COORD_BITS-1:0]          cy;
        logic [COORD_BITS-1:0]          cz;
        logic [omg_pkg::EXT_BITS-1:0]   ex;
        logic [omg_pkg::EXT_BITS-1:0]   ey;
        logic [omg_pkg::EXT_BITS-1:0]   ez;
        logic [omg_pkg::CONF_BITS-1:0]  conf;
        logic [omg_pkg::GSQ_BITS-1:0]   gsq;
    } t_cmd;

    typedef struct packed {
        logic [omg_pkg::CLASS_BITS-1:0] cls;
        logic [COORD_BITS-1:0]          cx;
        logic [COORD_BITS-1:0]          cy;
        logic [COORD_BITS-1:0]          cz;
        logic [omg_pkg::EXT_BITS-1:0]   ex;
        logic [omg_pkg::EXT_BITS-1:0]   ey;
        logic [omg_pkg::EXT_BITS-1:0]   ez;
        logic [omg_pkg::CONF_BITS-1:0]  conf;
    } t_entry;

    t_entry               r_mem [TABLE_DEPTH];
    omg_pkg::t_back_state r_state;
    omg_pkg::t_back_state n_state;
    t_cmd                 r_cmd;
    logic [CNTW-1:0]      r_cnt;
    logic [CNTW-1:0]      r_idx;

    // read stage
    logic                 r_p1_v;
    logic [AW-1:0]        r_p1_idx;
    t_entry               r_p1_data;
    // square stage
    logic                 r_p2_v;
    logic                 r_p2_match;
    logic [AW-1:0]        r_p2_idx;
    t_entry               r_p2_data;
    logic [SQW-1:0]       r_sq [3];
    // best so far
    logic                 r_found;
    logic [AW-1:0]        r_best;
    logic [SW-1:0]        r_best_d2;
    t_entry               r_best_data;

    logic                 r_out_v;
    omg_pkg::t_action     r_out_action;
    logic [omg_pkg::ID_BITS-1:0] r_out_id;
    logic [omg_pkg::ID_BITS-1:0] r_out_used;

    logic                 cmd_take;
    logic                 issue;
    logic                 finish;
    logic                 out_free;
    logic signed [COORD_BITS:0] dx, dy, dz;
    logic signed [SQW-1:0] sqx, sqy, sqz;
    logic [SW-1:0]        d2;
    logic                 do_merge;
    logic                 full;
    t_entry               merged;
    t_entry               fresh;
    logic [31:0]          id_wide;
    logic [31:0]          used_wide;
    logic [CNTW-1:0]      cnt_after;

    assign cmd_take    = i_cmd_valid && o_cmd_ready;
    assign issue       = (r_state == omg_pkg::ST_SCAN) && (r_idx < r_cnt);
    assign out_free    = !r_out_v || i_ready;
    assign full        = (r_cnt == FULL);

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        finish      = 1'b0;
        case (r_state)
            omg_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) n_state = omg_pkg::ST_SCAN;
            end
            omg_pkg::ST_SCAN: begin
                if (!issue) n_state = omg_pkg::ST_DRAIN;
            end
            omg_pkg::ST_DRAIN: begin
                if (!r_p1_v && !r_p2_v) n_state = omg_pkg::ST_DECIDE;
            end
            omg_pkg::ST_DECIDE: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = omg_pkg::ST_IDLE;
                end
            end
            default: n_state = omg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= omg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // distance datapath
    always_comb begin
        dx  = {r_cmd.cx[COORD_BITS-1], r_cmd.cx} - {r_p1_data.cx[COORD_BITS-1], r_p1_data.cx};
        dy  = {r_cmd.cy[COORD_BITS-1], r_cmd.cy} - {r_p1_data.cy[COORD_BITS-1], r_p1_data.cy};
        dz  = {r_cmd.cz[COORD_BITS-1], r_cmd.cz} - {r_p1_data.cz[COORD_BITS-1], r_p1_data.cz};
        sqx = dx * dx;
        sqy = dy * dy;
        sqz = dz * dz;
        d2  = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    // merge and append values
    always_comb begin
        logic [COORD_BITS:0] sx, sy, sz;
        logic [omg_pkg::EXT_BITS:0] se_x, se_y, se_z, sc;
        sx = {r_best_data.cx[COORD_BITS-1], r_best_data.cx}
           + {r_cmd.cx[COORD_BITS-1], r_cmd.cx};
        sy = {r_best_data.cy[COORD_BITS-1], r_best_data.cy}
           + {r_cmd.cy[COORD_BITS-1], r_cmd.cy};
        sz = {r_best_data.cz[COORD_BITS-1], r_best_data.cz}
           + {r_cmd.cz[COORD_BITS-1], r_cmd.cz};
        se_x = {1'b0, r_best_data.ex} + {1'b0, r_cmd.ex};
        se_y = {1'b0, r_best_data.ey} + {1'b0, r_cmd.ey};
        se_z = {1'b0, r_best_data.ez} + {1'b0, r_cmd.ez};
        sc   = {1'b0, r_best_data.conf} + {1'b0, r_cmd.conf};
        // halving: drop the low bit of the extended sum (sign-extended centres, zero-extended rest)
        merged.cls  = r_best_data.cls;
        merged.cx   = sx[COORD_BITS:1];
        merged.cy   = sy[COORD_BITS:1];
        merged.cz   = sz[COORD_BITS:1];
        merged.ex   = se_x[omg_pkg::EXT_BITS:1];
        merged.ey   = se_y[omg_pkg::EXT_BITS:1];
        merged.ez   = se_z[omg_pkg::EXT_BITS:1];
        merged.conf = sc[omg_pkg::CONF_BITS:1];

        fresh.cls  = r_cmd.cls;
        fresh.cx   = r_cmd.cx;
        fresh.cy   = r_cmd.cy;
        fresh.cz   = r_cmd.cz;
        fresh.ex   = r_cmd.ex;
        fresh.ey   = r_cmd.ey;
        fresh.ez   = r_cmd.ez;
        fresh.conf = r_cmd.conf;

        do_merge  = r_found && (CMPW'(r_best_d2) < CMPW'(r_cmd.gsq));
        cnt_after = (!do_merge && !full) ? r_cnt + 1'b1 : r_cnt;
        if (do_merge) begin
            id_wide = 32'(r_best) + 32'd1;
        end else if (!full) begin
            id_wide = 32'(cnt_after);
        end else begin
            id_wide = 32'd0;
        end
        used_wide = 32'(cnt_after);
    end

    // table memory: one read port for the scan, one write port at the end
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p1_data <= r_mem[r_idx[AW-1:0]];
        end
        if (finish && do_merge) begin
            r_mem[r_best] <= merged;
        end else if (finish && !full) begin
            r_mem[r_cnt[AW-1:0]] <= fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_found <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            if (cmd_take) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_p2_v && r_p2_match && (!r_found || d2 < r_best_d2)) begin
                r_found <= 1'b1;
            end
            if (finish) begin
                r_cnt   <= cnt_after;
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_cmd <= i_cmd;
        end
        r_p1_idx   <= r_idx[AW-1:0];
        r_p2_idx   <= r_p1_idx;
        r_p2_data  <= r_p1_data;
        r_p2_match <= (r_p1_data.cls == r_cmd.cls);
        r_sq[0]    <= sqx;
        r_sq[1]    <= sqy;
        r_sq[2]    <= sqz;
        if (r_p2_v && r_p2_match && (!r_found || d2 < r_best_d2)) begin
            r_best      <= r_p2_idx;
            r_best_d2   <= d2;
            r_best_data <= r_p2_data;
        end
        if (finish) begin
            r_out_action <= do_merge ? omg_pkg::ACT_MERGE
                          : (full ? omg_pkg::ACT_DROP : omg_pkg::ACT_INSERT);
            r_out_id     <= id_wide[omg_pkg::ID_BITS-1:0];
            r_out_used   <= used_wide[omg_pkg::ID_BITS-1:0];
        end
    end

    assign o_valid        = r_out_v;
    assign o_action       = r_out_action;
    assign o_track_id     = r_out_id;
    assign o_entries_used = r_out_used;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL)
        else $error("entry count beyond table depth");

    a_decide_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == omg_pkg::ST_DECIDE) |-> (!r_p1_v && !r_p2_v))
        else $error("decision taken with scan still in flight");

    a_cnt_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_cnt != $past(r_cnt))
            |-> r_out_v && (r_out_action == omg_pkg::ACT_INSERT))
        else $error("entry count moved without an insert");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_v |-> $past(r_state == omg_pkg::ST_SCAN))
        else $error("table read outside the scan");
endmodule

### verif/omg_tb_if.sv
// Note: the channel interfaces come with the RTL (hw/rtl/omg_if.sv) and are used as they are.
// This file holds only the map depth and the detection and result types that the testbench uses.
// Depends on omg_pkg.
package omg_tb_pkg;

    localparam int MAP_DEPTH = 64;

    typedef struct packed {
        logic [omg_pkg::CLASS_BITS-1:0] cls;
        logic signed [15:0]             cx, cy, cz;
        logic [omg_pkg::EXT_BITS-1:0]   ex, ey, ez;
        logic [omg_pkg::CONF_BITS-1:0]  conf;
    } t_detection;

    typedef struct packed {
        omg_pkg::t_action            action;
        logic [omg_pkg::ID_BITS-1:0] track_id;
        logic [omg_pkg::ID_BITS-1:0] entries_used;
    } t_assoc;
endpackage

### verif/tb.sv
// Self-checking testbench for object_map_gated_association_core.
// Drives detections and gate writes, predicts each association result and compares.
// Depends on omg_pkg, omg_if and omg_tb_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    omg_in_if #(.COORD_BITS(16)) in_ch();
    omg_cfg_if cfg_ch();
    omg_out_if out_ch();

    object_map_gated_association_core #(
        .TABLE_DEPTH(omg_tb_pkg::MAP_DEPTH), .COORD_BITS(16)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_cfg(cfg_ch.sink),
        .o_out(out_ch.source)
    );

    // predictor state
    logic [omg_pkg::GATE_BITS-1:0] gate_reg [omg_pkg::NUM_GATES];
    int                            map_count;
    omg_tb_pkg::t_detection        map_store [omg_tb_pkg::MAP_DEPTH];

    omg_tb_pkg::t_detection pending_dets[$];
    omg_tb_pkg::t_assoc     expected_assocs[$];
    int         send_idle_pct, recv_idle_pct;
    int         errors, accepted, watchdog, merges, inserts, drops;
    logic       cfg_busy;
    logic [omg_pkg::CFG_IDX_BITS-1:0] cfg_idx_q;
    logic [omg_pkg::GATE_BITS-1:0]    cfg_data_q;

    function automatic logic [omg_pkg::GATE_BITS-1:0] gate_of(
        logic [omg_pkg::CLASS_BITS-1:0] c);
        case (c)
            omg_pkg::CLASS_BOTTLE:  return gate_reg[omg_pkg::REG_BOTTLE_GATE];
            omg_pkg::CLASS_CHAIR:   return gate_reg[omg_pkg::REG_CHAIR_GATE];
            omg_pkg::CLASS_PERSON:  return gate_reg[omg_pkg::REG_PERSON_GATE];
            omg_pkg::CLASS_MONITOR: return gate_reg[omg_pkg::REG_MONITOR_GATE];
            default:                return gate_reg[omg_pkg::REG_DEFAULT_GATE];
        endcase
    endfunction

    function automatic logic signed [15:0] mean_s(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [16:0] s;
        s = a + b;
        return s[16:1];
    endfunction

    function automatic logic [15:0] mean_u(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[16:1];
    endfunction

    function automatic omg_tb_pkg::t_assoc associate(omg_tb_pkg::t_detection d);
        omg_tb_pkg::t_assoc r;
        bit found;
        int best;
        longint best_d2, d2, dx, dy, dz, g;
        found = 0; best = 0; best_d2 = 0;
        for (int i = 0; i < map_count; i++) begin
            if (map_store[i].cls == d.cls) begin
                dx = longint'(d.cx) - longint'(map_store[i].cx);
                dy = longint'(d.cy) - longint'(map_store[i].cy);
                dz = longint'(d.cz) - longint'(map_store[i].cz);
                d2 = dx * dx + dy * dy + dz * dz;
                if (!found || d2 < best_d2) begin
                    found = 1; best = i; best_d2 = d2;
                end
            end
        end
        g = longint'(gate_of(d.cls));
        if (found && best_d2 < g * g) begin
            map_store[best].cx = mean_s(map_store[best].cx, d.cx);
            map_store[best].cy = mean_s(map_store[best].cy, d.cy);
            map_store[best].cz = mean_s(map_store[best].cz, d.cz);
            map_store[best].ex = mean_u(map_store[best].ex, d.ex);
            map_store[best].ey = mean_u(map_store[best].ey, d.ey);
            map_store[best].ez = mean_u(map_store[best].ez, d.ez);
            map_store[best].conf = mean_u(map_store[best].conf, d.conf);
            r.action = omg_pkg::ACT_MERGE;
            r.track_id = omg_pkg::ID_BITS'(best + 1);
            merges++;
        end else if (map_count < omg_tb_pkg::MAP_DEPTH) begin
            map_store[map_count] = d;
            map_count++;
            r.action = omg_pkg::ACT_INSERT;
            r.track_id = omg_pkg::ID_BITS'(map_count);
            inserts++;
        end else begin
            r.action = omg_pkg::ACT_DROP;
            r.track_id = '0;
            drops++;
        end
        r.entries_used = omg_pkg::ID_BITS'(map_count);
        return r;
    endfunction

    function automatic void queue_det(omg_tb_pkg::t_detection d);
        pending_dets = {pending_dets, d};
    endfunction

    // detection driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                expected_assocs = {expected_assocs, associate(pending_dets.pop_front())};
            end
            if (pending_dets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                {in_ch.obj_class, in_ch.centre_x, in_ch.centre_y, in_ch.centre_z,
                 in_ch.extent_x, in_ch.extent_y, in_ch.extent_z, in_ch.confidence}
                    <= pending_dets[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // config driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index < omg_pkg::NUM_GATES) gate_reg[cfg_ch.index] = cfg_ch.data;
                cfg_ch.valid <= 1'b0;
                cfg_busy <= 1'b0;
            end else if (cfg_busy && !cfg_ch.valid) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= cfg_idx_q;
                cfg_ch.data <= cfg_data_q;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        omg_tb_pkg::t_assoc exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                accepted++;
                if (expected_assocs.size() == 0) begin
                    $display("%0t: unexpected result action=%0d id=%0d used=%0d", $time,
                             out_ch.action, out_ch.track_id, out_ch.entries_used);
                    errors++;
                end else begin
                    exp_r = expected_assocs.pop_front();
                    if (out_ch.action !== exp_r.action) begin
                        $display("%0t: action expected %0d actual %0d", $time,
                                 exp_r.action, out_ch.action);
                        errors++;
                    end
                    if (out_ch.track_id !== exp_r.track_id) begin
                        $display("%0t: track id expected %0d actual %0d", $time,
                                 exp_r.track_id, out_ch.track_id);
                        errors++;
                    end
                    if (out_ch.entries_used !== exp_r.entries_used) begin
                        $display("%0t: entries_used expected %0d actual %0d", $time,
                                 exp_r.entries_used, out_ch.entries_used);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            watchdog <= 0;
        else if (watchdog >= 20000) begin
            $display("object_map_gated_association_core test failed");
            $finish;
        end else
            watchdog <= watchdog + 1;
    end

    function automatic omg_tb_pkg::t_detection rand_det(int cls_hi, int spread);
        omg_tb_pkg::t_detection d;
        d.cls = omg_pkg::CLASS_BITS'($urandom_range(cls_hi));
        if ($urandom_range(9) == 0) begin
            d.cx = 16'($urandom); d.cy = 16'($urandom); d.cz = 16'($urandom);
        end else begin
            d.cx = 16'($signed($urandom_range(2 * spread)) - spread);
            d.cy = 16'($signed($urandom_range(2 * spread)) - spread);
            d.cz = 16'($signed($urandom_range(2 * spread)) - spread);
        end
        d.ex = 16'($urandom); d.ey = 16'($urandom); d.ez = 16'($urandom);
        d.conf = 16'($urandom);
        return d;
    endfunction

    task automatic write_gate(logic [omg_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [omg_pkg::GATE_BITS-1:0] val);
        cfg_idx_q = idx;
        cfg_data_q = val;
        cfg_busy = 1'b1;
        wait (cfg_busy == 1'b0);
        @(posedge i_clk);
    endtask

    task automatic drain();
        wait (pending_dets.size() == 0 && !in_ch.valid && expected_assocs.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    // one map for all phases: block has no clear, so map fills and later drops; phases keep going
    task automatic run_phase(int n, int cls_hi, int spread);
        for (int i = 0; i < n; i++) begin
            queue_det(rand_det(cls_hi, spread));
        end
        drain();
    endtask

    initial begin
        omg_tb_pkg::t_detection d;
        logic [15:0] gv;
        in_ch.valid = 0; in_ch.obj_class = 0; in_ch.centre_x = 0; in_ch.centre_y = 0;
        in_ch.centre_z = 0; in_ch.extent_x = 0; in_ch.extent_y = 0; in_ch.extent_z = 0;
        in_ch.confidence = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        out_ch.ready = 0;
        cfg_busy = 0; errors = 0; accepted = 0; watchdog = 0;
        merges = 0; inserts = 0; drops = 0; map_count = 0;
        gate_reg[omg_pkg::REG_DEFAULT_GATE] = omg_pkg::DEFAULT_GATE_RST;
        gate_reg[omg_pkg::REG_BOTTLE_GATE]  = omg_pkg::BOTTLE_GATE_RST;
        gate_reg[omg_pkg::REG_CHAIR_GATE]   = omg_pkg::CHAIR_GATE_RST;
        gate_reg[omg_pkg::REG_PERSON_GATE]  = omg_pkg::PERSON_GATE_RST;
        gate_reg[omg_pkg::REG_MONITOR_GATE] = omg_pkg::MONITOR_GATE_RST;
        send_idle_pct = 21; recv_idle_pct = 74;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, same-point merges, every special class, gate zero
        d = '0;
        queue_det(d);                              // insert into empty map
        queue_det(d);                              // exact merge
        d.cx = 16'sh7fff; d.cy = 16'sh7fff; d.cz = 16'sh7fff;
        d.ex = '1; d.ey = '1; d.ez = '1; d.conf = '1;
        queue_det(d);                              // far: insert
        d.cx = 16'sh8000; d.cy = 16'sh8000; d.cz = 16'sh8000;
        queue_det(d);
        queue_det(d);                              // merge at negative extreme
        for (int c = 0; c < 32; c += 1) begin
            if (c inside {5, 9, 15, 20, 21, 31}) begin
                d = '0; d.cls = omg_pkg::CLASS_BITS'(c); d.cx = 16'sd100;
                queue_det(d);
                d.cx = 16'sd160; queue_det(d);     // distance 60 vs gate
                d.cx = 16'sd450; queue_det(d);
            end
        end
        drain();

        write_gate(omg_pkg::REG_DEFAULT_GATE, 16'd0);   // no merges for default classes
        write_gate('1, 16'h1234);                       // unmapped index: ignored
        d = '0; d.cls = 5'd3;
        queue_det(d); queue_det(d);
        drain();

        // phase 1: tight gates, many classes -> map fills, drops start
        write_gate(omg_pkg::REG_DEFAULT_GATE, 16'd614);
        write_gate(omg_pkg::REG_BOTTLE_GATE, 16'd61);
        run_phase(300, 31, 3000);

        // phase 2: extreme gates, merges dominate on a full map
        send_idle_pct = 74; recv_idle_pct = 21;
        write_gate(omg_pkg::REG_DEFAULT_GATE, 16'hffff);
        write_gate(omg_pkg::REG_BOTTLE_GATE, 16'hffff);
        write_gate(omg_pkg::REG_CHAIR_GATE, 16'd0);
        write_gate(omg_pkg::REG_PERSON_GATE, 16'd1);
        write_gate(omg_pkg::REG_MONITOR_GATE, 16'hffff);
        run_phase(600, 20, 2000);

        // phase 3: random gates, no idling
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int r = 0; r < omg_pkg::NUM_GATES; r++) begin
            gv = 16'($urandom_range(4000));
            write_gate(omg_pkg::CFG_IDX_BITS'(r), gv);
        end
        run_phase(750, 20, 1500);

        $display("covered %0d results: %0d inserts, %0d merges, %0d drops", accepted,
                 inserts, merges, drops);
        if (errors == 0)
            $display("object_map_gated_association_core test passed");
        else
            $display("object_map_gated_association_core test failed");
        $finish;
    end
endmodule
